### hw/rtl/clip_rect_stack_macros.svh
// Assertion macros shared by the clip rectangle stack.
`ifndef CLIP_RECT_STACK_MACROS_SVH
`define CLIP_RECT_STACK_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define CRS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define CRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/crs_pkg.sv
package crs_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = COORD_BITS - 1;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic        [SIZE_BITS-1:0]  w;
      logic        [SIZE_BITS-1:0]  h;
   } clip_entry_type;

   typedef struct packed {
      logic                         req_type;
      logic signed [COORD_BITS-1:0] rect_x;
      logic signed [COORD_BITS-1:0] rect_y;
      logic        [SIZE_BITS-1:0]  rect_w;
      logic        [SIZE_BITS-1:0]  rect_h;
   } req_item_type;

   typedef struct packed {
      logic                         clip_active;
      logic signed [COORD_BITS-1:0] clip_x;
      logic signed [COORD_BITS-1:0] clip_y;
      logic        [SIZE_BITS-1:0]  clip_w;
      logic        [SIZE_BITS-1:0]  clip_h;
      status_type                   status;
   } rsp_item_type;

endpackage

### hw/rtl/crs_cell.sv
module crs_cell
   import crs_pkg::*;
(
   input  logic           clock,
   input  cell_op_type    op,
   input  clip_entry_type above,
   input  clip_entry_type below,
   output clip_entry_type entry
);

   clip_entry_type entry_ff;
   clip_entry_type entry_in;

   always_comb begin
      unique case (op)
         CELL_PUSH: entry_in = above;
         CELL_POP:  entry_in = below;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/crs_isect.sv
module crs_isect
   import crs_pkg::*;
(
   input  clip_entry_type rect,
   input  clip_entry_type top,
   input  logic           has_top,
   output clip_entry_type result
);

   localparam int WIDE = COORD_BITS + 2;

   logic signed [WIDE-1:0] rx, ry, rw, rh, tx, ty, tw, th;
   logic signed [WIDE-1:0] r_right, r_bottom, t_right, t_bottom;
   logic signed [WIDE-1:0] right, bottom, left_x, top_y, diff_w, diff_h;

   always_comb begin
      rx = WIDE'(rect.x);
      ry = WIDE'(rect.y);
      rw = WIDE'(rect.w);
      rh = WIDE'(rect.h);
      tx = WIDE'(top.x);
      ty = WIDE'(top.y);
      tw = WIDE'(top.w);
      th = WIDE'(top.h);
      r_right  = rx + rw;
      r_bottom = ry + rh;
      t_right  = tx + tw;
      t_bottom = ty + th;
      right  = (r_right < t_right) ? r_right : t_right;
      bottom = (r_bottom < t_bottom) ? r_bottom : t_bottom;
      left_x = (rx > tx) ? rx : tx;
      top_y  = (ry > ty) ? ry : ty;
      diff_w = right - left_x;
      diff_h = bottom - top_y;
      if (has_top) begin
         result.x = left_x[COORD_BITS-1:0];
         result.y = top_y[COORD_BITS-1:0];
         result.w = (diff_w < 0) ? '0 : diff_w[SIZE_BITS-1:0];
         result.h = (diff_h < 0) ? '0 : diff_h[SIZE_BITS-1:0];
      end else begin
         result = rect;
      end
   end

endmodule

### hw/rtl/clip_rect_stack.sv
// Nested clip rectangle stack.
// The req channel carries one item per push or pop. A push intersects its
// rectangle with the current top entry, if any, and stores the result if
// the stack has room; a pop drops the top entry. Each item yields exactly
// one rsp item: the clip now in force, or no clip, with a status code.
// The stack is a row of cells, one entry each, with the top in the first
// cell; a push shifts every cell one place down and a pop one place up.
// The rsp item appears in the cycle after its req item is taken. One item is
// taken in every cycle while the rsp side does not stall, since only the
// top entry feeds the intersection logic.
// When rsp_stall holds a waiting item, req_stall is raised until the item
// is taken, so that no result is lost.
// Reset empties the stack and drops any waiting rsp item; no clearing pass
// is needed and an item may be sent in the first cycle after reset.
`include "clip_rect_stack_macros.svh"

module clip_rect_stack
   import crs_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(STACK_DEPTH);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   logic           accept;
   cell_op_type    op;
   clip_entry_type rect, new_entry;
   clip_entry_type cell_q [STACK_DEPTH];

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign rect.x = req_data.rect_x;
   assign rect.y = req_data.rect_y;
   assign rect.w = req_data.rect_w;
   assign rect.h = req_data.rect_h;

   crs_isect u_isect (
      .rect    (rect),
      .top     (cell_q[0]),
      .has_top (count_ff != '0),
      .result  (new_entry)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      clip_entry_type above, below;
      if (i == 0) begin : g_first
         assign above = new_entry;
      end else begin : g_rest
         assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_q[i];
      end else begin : g_mid
         assign below = cell_q[i+1];
      end
      crs_cell u_cell (
         .clock (clock),
         .op    (op),
         .above (above),
         .below (below),
         .entry (cell_q[i])
      );
   end

   always_comb begin
      clip_entry_type shown;
      logic           active;
      status_type     status;
      op       = CELL_HOLD;
      count_in = count_ff;
      shown    = cell_q[0];
      active   = 1'b1;
      status   = STATUS_DONE;
      if (req_data.req_type == REQ_POP) begin
         if (count_ff == '0) begin
            active = 1'b0;
            status = STATUS_POP_EMPTY;
         end else begin
            op       = CELL_POP;
            count_in = count_ff - 1'b1;
            shown    = cell_q[1];
            active   = (count_ff != CNT_BITS'(1));
         end
      end else begin
         if (count_ff == FULL_COUNT) begin
            status = STATUS_PUSH_FULL;
         end else begin
            op       = CELL_PUSH;
            count_in = count_ff + 1'b1;
            shown    = new_entry;
         end
      end
      if (!accept) begin
         op       = CELL_HOLD;
         count_in = count_ff;
      end

      rsp_data_in.clip_active = active;
      rsp_data_in.clip_x      = active ? shown.x : '0;
      rsp_data_in.clip_y      = active ? shown.y : '0;
      rsp_data_in.clip_w      = active ? shown.w : '0;
      rsp_data_in.clip_h      = active ? shown.h : '0;
      rsp_data_in.status      = status;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CRS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "stack count beyond depth")
   `CRS_ASSERT_NEXT(a_push_grows, clock, reset, accept && req_data.req_type == REQ_PUSH && count_ff != FULL_COUNT, count_ff == $past(count_ff) + 1'b1 && rsp_data.clip_active, "push did not grow the stack")
   `CRS_ASSERT_NEXT(a_pop_shrinks, clock, reset, accept && req_data.req_type == REQ_POP && count_ff != '0, count_ff == $past(count_ff) - 1'b1 && rsp_data.status == STATUS_DONE, "pop did not shrink the stack")
   `CRS_ASSERT_ALWAYS(a_full_status, clock, reset, !(rsp_valid && rsp_data.status == STATUS_PUSH_FULL) || count_ff == FULL_COUNT, "full status with room on the stack")

endmodule

### tb/sv/clip_rect_checker.sv
`timescale 1ns / 1ps

module clip_rect_checker
   import crs_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_data,
   output int           fail_count,
   output int           clips_due_count
);

   clip_entry_type clip_rows [STACK_DEPTH];
   int             row_count = 0;
   int             fault_total = 0;
   rsp_item_type   clips_due [$];

   function automatic rsp_item_type report_clip(logic active, clip_entry_type e,
                                                status_type st);
      rsp_item_type r;
      r = '0;
      r.status = st;
      if (active) begin
         r.clip_active = 1'b1;
         r.clip_x      = e.x;
         r.clip_y      = e.y;
         r.clip_w      = e.w;
         r.clip_h      = e.h;
      end
      return r;
   endfunction

   task automatic apply_item(input req_item_type it, output rsp_item_type res);
      clip_entry_type top, fresh;
      int ax, ay, cx, cy, right, bottom;
      if (it.req_type == REQ_POP) begin
         if (row_count == 0) begin
            res = report_clip(1'b0, '0, STATUS_POP_EMPTY);
         end else begin
            row_count--;
            if (row_count == 0) begin
               res = report_clip(1'b0, '0, STATUS_DONE);
            end else begin
               res = report_clip(1'b1, clip_rows[row_count-1], STATUS_DONE);
            end
         end
      end else if (row_count >= STACK_DEPTH) begin
         res = report_clip(1'b1, clip_rows[STACK_DEPTH-1], STATUS_PUSH_FULL);
      end else begin
         fresh.x = it.rect_x;
         fresh.y = it.rect_y;
         fresh.w = it.rect_w;
         fresh.h = it.rect_h;
         if (row_count != 0) begin
            top    = clip_rows[row_count-1];
            ax     = int'(it.rect_x);
            ay     = int'(it.rect_y);
            cx     = int'(top.x);
            cy     = int'(top.y);
            right  = ax + int'(it.rect_w);
            bottom = ay + int'(it.rect_h);
            if (cx + int'(top.w) < right) begin
               right = cx + int'(top.w);
            end
            if (cy + int'(top.h) < bottom) begin
               bottom = cy + int'(top.h);
            end
            if (cx > ax) begin
               ax = cx;
            end
            if (cy > ay) begin
               ay = cy;
            end
            fresh.x = COORD_BITS'(ax);
            fresh.y = COORD_BITS'(ay);
            fresh.w = (right > ax) ? SIZE_BITS'(right - ax) : '0;
            fresh.h = (bottom > ay) ? SIZE_BITS'(bottom - ay) : '0;
         end
         clip_rows[row_count] = fresh;
         row_count++;
         res = report_clip(1'b1, fresh, STATUS_DONE);
      end
   endtask

   function automatic int compare_clip(rsp_item_type want, rsp_item_type got);
      int bad = 0;
      if (got.clip_active !== want.clip_active) begin
         $error("clip_active: expected %0d, got %0d", want.clip_active, got.clip_active);
         bad++;
      end
      if (got.clip_x !== want.clip_x) begin
         $error("clip_x: expected %0d, got %0d", want.clip_x, got.clip_x);
         bad++;
      end
      if (got.clip_y !== want.clip_y) begin
         $error("clip_y: expected %0d, got %0d", want.clip_y, got.clip_y);
         bad++;
      end
      if (got.clip_w !== want.clip_w) begin
         $error("clip_w: expected %0d, got %0d", want.clip_w, got.clip_w);
         bad++;
      end
      if (got.clip_h !== want.clip_h) begin
         $error("clip_h: expected %0d, got %0d", want.clip_h, got.clip_h);
         bad++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         bad++;
      end
      return bad;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         row_count = 0;
         clips_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (clips_due.size() == 0) begin
               $error("Result item arrived with no clip expected.");
               fault_total++;
            end else begin
               fault_total += compare_clip(clips_due.pop_front(), rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            apply_item(req_data, want);
            clips_due.push_back(want);
         end
      end
      fail_count      <= fault_total;
      clips_due_count <= clips_due.size();
   end

endmodule

### tb/sv/clip_rect_stack_tb.sv
`timescale 1ns / 1ps

module clip_rect_stack_tb;
   import crs_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         calm = 1'b0;
   int           fail_count;
   int           clips_due_count;

   clip_rect_stack uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   clip_rect_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .clips_due_count (clips_due_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 18);
   end

   function automatic req_item_type make_rect(logic kind, int x, int y, int w, int h);
      req_item_type it;
      it.req_type = kind;
      it.rect_x   = COORD_BITS'(x);
      it.rect_y   = COORD_BITS'(y);
      it.rect_w   = SIZE_BITS'(w);
      it.rect_h   = SIZE_BITS'(h);
      return it;
   endfunction

   function automatic req_item_type random_rect(logic kind);
      req_item_type it;
      it.req_type = kind;
      if ($urandom_range(3) == 0) begin
         it.rect_x = COORD_BITS'($urandom);
         it.rect_y = COORD_BITS'($urandom);
         it.rect_w = SIZE_BITS'($urandom);
         it.rect_h = SIZE_BITS'($urandom);
      end else begin
         it.rect_x = COORD_BITS'(int'($urandom_range(2000)) - 1000);
         it.rect_y = COORD_BITS'(int'($urandom_range(2000)) - 1000);
         it.rect_w = SIZE_BITS'($urandom_range(1500));
         it.rect_h = SIZE_BITS'($urandom_range(1500));
      end
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      while (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (clips_due_count != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int push_pct;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(random_rect(REQ_POP));
      send_item(make_rect(REQ_PUSH, -32768, -32768, 32767, 32767));
      send_item(make_rect(REQ_PUSH, 32767, 32767, 32767, 32767));
      send_item(random_rect(REQ_POP));
      send_item(make_rect(REQ_PUSH, 0, 0, 0, 0));
      send_item(make_rect(REQ_PUSH, -5, -5, 10, 10));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      send_item(make_rect(REQ_PUSH, 100, 200, 300, 400));
      send_item(make_rect(REQ_PUSH, 50, 250, 100, 1000));
      send_item(make_rect(REQ_PUSH, -1000, -1000, 5000, 5000));
      send_item(make_rect(REQ_PUSH, 0, 0, 99, 100));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      send_item(random_rect(REQ_POP));
      drain_results();

      for (int seg = 0; seg < 16; seg++) begin
         calm <= (seg == 6);
         push_pct = ($urandom_range(2) == 0) ? 80 : ($urandom_range(1) ? 50 : 25);
         for (int i = 0; i < 96; i++) begin
            send_item(random_rect(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP));
         end
         if (seg % 5 == 4) begin
            drain_results();
         end
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/crs_pkg.sv
hw/rtl/crs_cell.sv
hw/rtl/crs_isect.sv
hw/rtl/clip_rect_stack.sv
tb/sv/clip_rect_checker.sv
tb/sv/clip_rect_stack_tb.sv
